// ----- sv/bsbc_pkg.sv -----
// shared constants and types of the binned spectrum baseline clip block
`default_nettype none
package bsbc_pkg;

   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 3;
   localparam int INDEX_W   = 12;
   localparam int BOUND_W   = 12;
   localparam int HW_W      = 10;
   localparam int BIN_NUM_W = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 11;
   localparam int NUM_BINS_W = 11;
   localparam int NUM_ITER_W = 7;

   localparam int DEF_MAX_SAMPLES    = 4096;
   localparam int DEF_MAX_BINS       = 1024;
   localparam int DEF_MAX_ITERATIONS = 64;

   localparam logic [NUM_BINS_W-1:0] NUM_BINS_RESET = NUM_BINS_W'(1024);
   localparam logic [NUM_ITER_W-1:0] NUM_ITER_RESET = NUM_ITER_W'(0);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_SAMPLE = 3'd0,
      CMD_LOAD_BOUNDS = 3'd1,
      CMD_LOAD_WIDTH  = 3'd2,
      CMD_COMPUTE     = 3'd3,
      CMD_READ        = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BINS       = 1'd0,
      CSR_NUM_ITERATIONS = 1'd1
   } csr_type;

endpackage
`default_nettype wire

// ----- sv/bsbc_if.sv -----
// request and response channel interfaces
`default_nettype none
interface bsbc_req_if;
   import bsbc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [INDEX_W-1:0]   index;
   logic signed [VALUE_W-1:0] sample;
   logic [BOUND_W-1:0]   bin_first;
   logic [BOUND_W-1:0]   bin_last;
   logic [HW_W-1:0]      half_width;
   modport source (output valid, command, index, sample, bin_first, bin_last, half_width,
                   input ready);
   modport sink (input valid, command, index, sample, bin_first, bin_last, half_width,
                 output ready);
endinterface

interface bsbc_rsp_if;
   import bsbc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] baseline_value;
   logic [BIN_NUM_W-1:0]      bin_number;
   logic                      done_res;
   logic                      status;
   modport source (output valid, baseline_value, bin_number, done_res, status, input ready);
   modport sink (input valid, baseline_value, bin_number, done_res, status, output ready);
endinterface
`default_nettype wire

// ----- sv/binned_spectrum_baseline_clip.sv -----
// top level: stores, bin mean, iterative window-mean clipping, readback
// Load commands may stream back to back. A read latches the baseline
// memory entry and registers it into the response once the response channel
// is free. A compute runs entirely out of the sample, bounds, width and
// baseline memories through one read port each and a shared bit-serial
// divider: a mean for each bin, then per iteration a clip of each of the
// 2*(n-2) inner bins, a forward and a backward pass, against its window mean.
// No request is taken while a compute or read is in progress. No memory is
// cleared after reset; entries are valid once written.
`default_nettype none
module binned_spectrum_baseline_clip #(
   parameter int MAX_SAMPLES    = bsbc_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_BINS       = bsbc_pkg::DEF_MAX_BINS,
   parameter int MAX_ITERATIONS = bsbc_pkg::DEF_MAX_ITERATIONS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bsbc_req_if.sink                              req_if,
   bsbc_rsp_if.source                            rsp_if,
   input  wire logic                             csr_write_enable,
   input  wire logic [bsbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bsbc_pkg::CSR_W-1:0]       csr_write_data
);
   import bsbc_pkg::*;

   localparam int SMP_AW = $clog2(MAX_SAMPLES);
   localparam int SMP_CW = SMP_AW + 1;
   localparam int BIN_AW = $clog2(MAX_BINS);
   localparam int NB_W   = BIN_AW + 1;
   localparam int IT_AW  = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
   localparam int IT_W   = $clog2(MAX_ITERATIONS + 1);
   localparam int DEN_W  = (SMP_CW > NB_W + 1) ? SMP_CW : NB_W + 1;
   localparam int SUM_W  = VALUE_W + DEN_W;
   localparam int DC_W   = $clog2(SUM_W + 1);
   localparam int HWC_W  = (NB_W > HW_W) ? NB_W : HW_W;
   localparam int BL_W   = VALUE_W + 1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_OUT, ST_B_RD, ST_B_CHK, ST_B_SRD, ST_B_SACC, ST_B_WR,
      ST_CLIP, ST_W_RD, ST_W_GET, ST_C_START, ST_C_RD, ST_C_ACC, ST_C_WR,
      ST_DSTART, ST_DIV, ST_DONE
   } state_type;

   // memories
   logic [VALUE_W-1:0]   sp_mem [MAX_SAMPLES];
   logic [2*BOUND_W-1:0] bd_mem [MAX_BINS];
   logic [HW_W-1:0]      wd_mem [MAX_ITERATIONS];
   logic [BL_W-1:0]      bl_mem [MAX_BINS];

   logic                 sp_we, sp_re, bd_we, bd_re, wd_we, wd_re, bl_we, bl_re;
   logic [SMP_AW-1:0]    sp_waddr, sp_raddr;
   logic [BIN_AW-1:0]    bd_waddr, bd_raddr, bl_waddr, bl_raddr;
   logic [IT_AW-1:0]     wd_waddr, wd_raddr;
   logic [BL_W-1:0]      bl_wdata;
   logic [VALUE_W-1:0]   sp_q;
   logic [2*BOUND_W-1:0] bd_q;
   logic [HW_W-1:0]      wd_q;
   logic [BL_W-1:0]      bl_q;

   always_ff @(posedge clock) begin
      if (sp_we) sp_mem[sp_waddr] <= req_if.sample;
      if (sp_re) sp_q <= sp_mem[sp_raddr];
   end
   always_ff @(posedge clock) begin
      if (bd_we) bd_mem[bd_waddr] <= {req_if.bin_first, req_if.bin_last};
      if (bd_re) bd_q <= bd_mem[bd_raddr];
   end
   always_ff @(posedge clock) begin
      if (wd_we) wd_mem[wd_waddr] <= req_if.half_width;
      if (wd_re) wd_q <= wd_mem[wd_raddr];
   end
   always_ff @(posedge clock) begin
      if (bl_we) bl_mem[bl_waddr] <= bl_wdata;
      if (bl_re) bl_q <= bl_mem[bl_raddr];
   end

   // registers
   state_type              state_ff, state_in;
   logic [NUM_BINS_W-1:0]  num_bins_ff, num_bins_in;
   logic [NUM_ITER_W-1:0]  num_iter_ff, num_iter_in;
   logic [NB_W-1:0]        n_ff, n_in, bin_ff, bin_in, j_ff, j_in, pos_ff, pos_in;
   logic [NB_W-1:0]        k_ff, k_in, kend_ff, kend_in;
   logic [IT_W-1:0]        its_ff, its_in, it_ff, it_in;
   logic [SMP_AW-1:0]      s_ff, s_in, hi_ff, hi_in;
   logic [SUM_W-1:0]       acc_ff, acc_in, dnum_ff, dnum_in;
   logic [DEN_W-1:0]       den_ff, den_in, drem_ff, drem_in;
   logic [DC_W-1:0]        dcnt_ff, dcnt_in;
   logic                   dneg_ff, dneg_in, clip_ff, clip_in, pass_ff, pass_in;
   logic                   any_bad_ff, any_bad_in, rd_hit_ff, rd_hit_in;
   logic                   cur_bad_ff, cur_bad_in;
   logic [VALUE_W-1:0]     cur_ff, cur_in;
   logic [HW_W-1:0]        hw_ff, hw_in;
   logic [BIN_NUM_W-1:0]   rd_idx_ff, rd_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_done_ff, rsp_done_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [BIN_NUM_W-1:0]   rsp_bin_ff, rsp_bin_in;

   logic                   accept, rsp_free, last_bin;
   logic [NB_W-1:0]        n_eff, pos_c, right_c, v_c;
   logic [HWC_W-1:0]       vmin_c;
   logic [IT_W-1:0]        its_eff;
   logic [BOUND_W-1:0]     lo_c, hi_c;
   logic                   bad_c;
   logic [DEN_W:0]         trial_c;
   logic                   qbit_c;
   logic [VALUE_W-1:0]     mean_c;
   logic [SUM_W-1:0]       mag_c;

   assign req_if.ready = (state_ff == ST_IDLE) && !reset;
   assign accept = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign last_bin = (bin_ff == n_ff - NB_W'(1));

   assign n_eff = (32'(num_bins_ff) > 32'(MAX_BINS)) ? NB_W'(MAX_BINS) : NB_W'(num_bins_ff);
   assign its_eff = (32'(num_iter_ff) > 32'(MAX_ITERATIONS)) ? IT_W'(MAX_ITERATIONS)
                                                            : IT_W'(num_iter_ff);

   assign lo_c = bd_q[2*BOUND_W-1:BOUND_W];
   assign hi_c = bd_q[BOUND_W-1:0];
   assign bad_c = (lo_c > hi_c) || (32'(hi_c) >= 32'(MAX_SAMPLES));

   assign pos_c = pass_ff ? (n_ff - NB_W'(1) - j_ff) : j_ff;
   assign right_c = n_ff - NB_W'(1) - pos_c;
   assign vmin_c = (HWC_W'(pos_c) < HWC_W'(hw_ff)) ? HWC_W'(pos_c) : HWC_W'(hw_ff);
   assign v_c = (vmin_c < HWC_W'(right_c)) ? NB_W'(vmin_c) : right_c;

   assign trial_c = {drem_ff, dnum_ff[SUM_W-1]};
   assign qbit_c = (trial_c >= {1'b0, den_ff});
   assign mean_c = dneg_ff ? (VALUE_W'(0) - dnum_ff[VALUE_W-1:0]) : dnum_ff[VALUE_W-1:0];
   assign mag_c = acc_ff[SUM_W-1] ? (SUM_W'(0) - acc_ff) : acc_ff;

   always_comb begin
      state_in = state_ff;
      num_bins_in = num_bins_ff;
      num_iter_in = num_iter_ff;
      n_in = n_ff; bin_in = bin_ff; j_in = j_ff; pos_in = pos_ff;
      k_in = k_ff; kend_in = kend_ff; its_in = its_ff; it_in = it_ff;
      s_in = s_ff; hi_in = hi_ff; acc_in = acc_ff; dnum_in = dnum_ff;
      den_in = den_ff; drem_in = drem_ff; dcnt_in = dcnt_ff; dneg_in = dneg_ff;
      clip_in = clip_ff; pass_in = pass_ff; any_bad_in = any_bad_ff;
      rd_hit_in = rd_hit_ff; cur_bad_in = cur_bad_ff; cur_in = cur_ff; hw_in = hw_ff;
      rd_idx_in = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_done_in = rsp_done_ff; rsp_status_in = rsp_status_ff;
      rsp_value_in = rsp_value_ff; rsp_bin_in = rsp_bin_ff;

      sp_we = 1'b0; sp_waddr = SMP_AW'(req_if.index); sp_re = 1'b0; sp_raddr = s_ff;
      bd_we = 1'b0; bd_waddr = BIN_AW'(req_if.index); bd_re = 1'b0;
      bd_raddr = bin_ff[BIN_AW-1:0];
      wd_we = 1'b0; wd_waddr = IT_AW'(req_if.index); wd_re = 1'b0; wd_raddr = IT_AW'(it_ff);
      bl_we = 1'b0; bl_waddr = bin_ff[BIN_AW-1:0]; bl_wdata = {1'b0, mean_c};
      bl_re = 1'b0; bl_raddr = k_ff[BIN_AW-1:0];

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NUM_BINS:       num_bins_in = csr_write_data[NUM_BINS_W-1:0];
            CSR_NUM_ITERATIONS: num_iter_in = csr_write_data[NUM_ITER_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_if.command)
                  CMD_LOAD_SAMPLE: sp_we = (32'(req_if.index) < 32'(MAX_SAMPLES));
                  CMD_LOAD_BOUNDS: bd_we = (32'(req_if.index) < 32'(MAX_BINS));
                  CMD_LOAD_WIDTH:  wd_we = (32'(req_if.index) < 32'(MAX_ITERATIONS));
                  CMD_COMPUTE: begin
                     n_in = n_eff;
                     its_in = its_eff;
                     bin_in = '0;
                     any_bad_in = 1'b0;
                     clip_in = 1'b0;
                     state_in = (n_eff == '0) ? ST_DONE : ST_B_RD;
                  end
                  CMD_READ: begin
                     rd_hit_in = (32'(req_if.index) < 32'(n_eff));
                     rd_idx_in = req_if.index[BIN_NUM_W-1:0];
                     bl_re = 1'b1;
                     bl_raddr = BIN_AW'(req_if.index);
                     state_in = ST_RD_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_hit_ff ? bl_q[VALUE_W-1:0] : '0;
               rsp_status_in = rd_hit_ff ? bl_q[VALUE_W] : 1'b1;
               rsp_bin_in = rd_idx_ff;
               rsp_done_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_B_RD: begin
            bd_re = 1'b1;
            state_in = ST_B_CHK;
         end
         ST_B_CHK: begin
            if (bad_c) begin
               bl_we = 1'b1;
               bl_wdata = {1'b1, VALUE_W'(0)};
               any_bad_in = 1'b1;
               bin_in = bin_ff + NB_W'(1);
               state_in = last_bin ? ST_CLIP : ST_B_RD;
            end else begin
               s_in = SMP_AW'(lo_c);
               hi_in = SMP_AW'(hi_c);
               den_in = DEN_W'(SMP_CW'(hi_c) - SMP_CW'(lo_c) + SMP_CW'(1));
               acc_in = '0;
               state_in = ST_B_SRD;
            end
         end
         ST_B_SRD: begin
            sp_re = 1'b1;
            state_in = ST_B_SACC;
         end
         ST_B_SACC: begin
            acc_in = acc_ff + {{(SUM_W-VALUE_W){sp_q[VALUE_W-1]}}, sp_q};
            if (s_ff == hi_ff) begin
               state_in = ST_DSTART;
            end else begin
               s_in = s_ff + SMP_AW'(1);
               state_in = ST_B_SRD;
            end
         end
         ST_B_WR: begin
            bl_we = 1'b1;
            bin_in = bin_ff + NB_W'(1);
            state_in = last_bin ? ST_CLIP : ST_B_RD;
         end
         ST_CLIP: begin
            clip_in = 1'b1;
            it_in = '0;
            state_in = (n_ff < NB_W'(3) || its_ff == '0) ? ST_DONE : ST_W_RD;
         end
         ST_W_RD: begin
            wd_re = 1'b1;
            state_in = ST_W_GET;
         end
         ST_W_GET: begin
            hw_in = wd_q;
            pass_in = 1'b0;
            j_in = NB_W'(1);
            state_in = ST_C_START;
         end
         ST_C_START: begin
            pos_in = pos_c;
            k_in = pos_c - v_c;
            kend_in = pos_c + v_c;
            den_in = DEN_W'({v_c, 1'b1});
            acc_in = '0;
            state_in = ST_C_RD;
         end
         ST_C_RD: begin
            bl_re = 1'b1;
            state_in = ST_C_ACC;
         end
         ST_C_ACC: begin
            acc_in = acc_ff + {{(SUM_W-VALUE_W){bl_q[VALUE_W-1]}}, bl_q[VALUE_W-1:0]};
            if (k_ff == pos_ff) begin
               cur_in = bl_q[VALUE_W-1:0];
               cur_bad_in = bl_q[VALUE_W];
            end
            if (k_ff == kend_ff) begin
               state_in = ST_DSTART;
            end else begin
               k_in = k_ff + NB_W'(1);
               state_in = ST_C_RD;
            end
         end
         ST_C_WR: begin
            bl_waddr = pos_ff[BIN_AW-1:0];
            bl_wdata = {cur_bad_ff, mean_c};
            bl_we = ($signed(mean_c) < $signed(cur_ff));
            if (j_ff == n_ff - NB_W'(2)) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  j_in = NB_W'(1);
                  state_in = ST_C_START;
               end else if (it_ff == its_ff - IT_W'(1)) begin
                  state_in = ST_DONE;
               end else begin
                  it_in = it_ff + IT_W'(1);
                  state_in = ST_W_RD;
               end
            end else begin
               j_in = j_ff + NB_W'(1);
               state_in = ST_C_START;
            end
         end
         ST_DSTART: begin
            dneg_in = acc_ff[SUM_W-1];
            dnum_in = mag_c + SUM_W'(den_ff >> 1);
            drem_in = '0;
            dcnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            drem_in = qbit_c ? DEN_W'(trial_c - {1'b0, den_ff}) : trial_c[DEN_W-1:0];
            dnum_in = {dnum_ff[SUM_W-2:0], qbit_c};
            dcnt_in = dcnt_ff + DC_W'(1);
            if (dcnt_ff == DC_W'(SUM_W - 1)) begin
               state_in = clip_ff ? ST_C_WR : ST_B_WR;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_status_in = any_bad_ff;
               rsp_bin_in = '0;
               rsp_done_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         num_bins_ff <= NUM_BINS_RESET;
         num_iter_ff <= NUM_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         num_bins_ff <= num_bins_in;
         num_iter_ff <= num_iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in; bin_ff <= bin_in; j_ff <= j_in; pos_ff <= pos_in;
      k_ff <= k_in; kend_ff <= kend_in; its_ff <= its_in; it_ff <= it_in;
      s_ff <= s_in; hi_ff <= hi_in; acc_ff <= acc_in; dnum_ff <= dnum_in;
      den_ff <= den_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in; dneg_ff <= dneg_in;
      clip_ff <= clip_in; pass_ff <= pass_in; any_bad_ff <= any_bad_in;
      rd_hit_ff <= rd_hit_in; cur_bad_ff <= cur_bad_in; cur_ff <= cur_in; hw_ff <= hw_in;
      rd_idx_ff <= rd_idx_in;
      rsp_done_ff <= rsp_done_in; rsp_status_ff <= rsp_status_in;
      rsp_value_ff <= rsp_value_in; rsp_bin_ff <= rsp_bin_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.baseline_value = rsp_value_ff;
   assign rsp_if.bin_number = rsp_bin_ff;
   assign rsp_if.done_res = rsp_done_ff;
   assign rsp_if.status = rsp_status_ff;

`ifndef SYNTHESIS
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dcnt_ff < DC_W'(SUM_W))
      else $error("divider ran past its last step");
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.command == CMD_COMPUTE |=> state_ff != ST_IDLE)
      else $error("compute transfer did not start the sequencer");
   a_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_C_ACC |-> k_ff <= kend_ff && k_ff < n_ff)
      else $error("window walk left its bounds");
   a_done_flag: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_done_ff |-> $past(state_ff) == ST_DONE)
      else $error("done flag raised outside a compute result");
`endif

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for the binned spectrum baseline clip block: load, compute, read with prediction
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import bsbc_pkg::*;

   class baseline_scoreboard;
      typedef struct {
         logic signed [VALUE_W-1:0] value;
         logic [BIN_NUM_W-1:0]      bin;
         logic                      done;
         logic                      status;
      } baseline_rsp_type;

      int                  sample_mem [DEF_MAX_SAMPLES];
      bit [BOUND_W-1:0]    first_mem [DEF_MAX_BINS];
      bit [BOUND_W-1:0]    last_mem [DEF_MAX_BINS];
      bit [HW_W-1:0]       width_mem [DEF_MAX_ITERATIONS];
      int                  baseline_mem [DEF_MAX_BINS];
      bit                  bad_mem [DEF_MAX_BINS];
      int unsigned         bins_cfg;
      int unsigned         iters_cfg;
      baseline_rsp_type    expected_q [$];
      int                  errors;

      function new();
         bins_cfg  = int'(NUM_BINS_RESET);
         iters_cfg = int'(NUM_ITER_RESET);
         errors    = 0;
      endfunction

      function int unsigned active_bins();
         return (bins_cfg < DEF_MAX_BINS) ? bins_cfg : DEF_MAX_BINS;
      endfunction

      function void write_csr(csr_type idx, int unsigned val);
         if (idx == CSR_NUM_BINS)
            bins_cfg = val & 32'h7ff;
         else
            iters_cfg = val & 32'h7f;
      endfunction

      function int round_mean(longint sum, longint cnt);
         longint q;
         if (sum >= 0)
            q = (sum + cnt / 2) / cnt;
         else
            q = -((-sum + cnt / 2) / cnt);
         return int'(q);
      endfunction

      function void clip_bin(int pos, int n, int hw);
         int     v;
         longint sum;
         int     m;
         v = (pos < hw) ? pos : hw;
         if (n - 1 - pos < v)
            v = n - 1 - pos;
         sum = 0;
         for (int k = pos - v; k <= pos + v; k++)
            sum += baseline_mem[k];
         m = round_mean(sum, 2 * v + 1);
         if (m < baseline_mem[pos])
            baseline_mem[pos] = m;
      endfunction

      function bit run_compute();
         int     n;
         int     its;
         bit     any_bad;
         longint sum;
         n = active_bins();
         its = (iters_cfg < DEF_MAX_ITERATIONS) ? iters_cfg : DEF_MAX_ITERATIONS;
         any_bad = 0;
         for (int b = 0; b < n; b++) begin
            if (first_mem[b] > last_mem[b]) begin
               baseline_mem[b] = 0;
               bad_mem[b] = 1;
               any_bad = 1;
            end else begin
               sum = 0;
               for (int s = first_mem[b]; s <= last_mem[b]; s++)
                  sum += sample_mem[s];
               baseline_mem[b] = round_mean(sum, last_mem[b] - first_mem[b] + 1);
               bad_mem[b] = 0;
            end
         end
         if (n >= 3) begin
            for (int it = 0; it < its; it++) begin
               for (int j = 1; j + 1 < n; j++)
                  clip_bin(j, n, width_mem[it]);
               for (int j = 1; j + 1 < n; j++)
                  clip_bin(n - 1 - j, n, width_mem[it]);
            end
         end
         return any_bad;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                 logic signed [VALUE_W-1:0] sample,
                                 logic [BOUND_W-1:0] first,
                                 logic [BOUND_W-1:0] last, logic [HW_W-1:0] hw);
         baseline_rsp_type r;
         case (cmd)
            CMD_LOAD_SAMPLE: sample_mem[idx] = sample;
            CMD_LOAD_BOUNDS: begin
               if (idx < DEF_MAX_BINS) begin
                  first_mem[idx] = first;
                  last_mem[idx] = last;
               end
            end
            CMD_LOAD_WIDTH: begin
               if (idx < DEF_MAX_ITERATIONS)
                  width_mem[idx] = hw;
            end
            CMD_COMPUTE: begin
               r.value = 0;
               r.bin = 0;
               r.done = 1;
               r.status = run_compute();
               expected_q.push_back(r);
            end
            CMD_READ: begin
               if (idx < active_bins()) begin
                  r.value = baseline_mem[idx];
                  r.status = bad_mem[idx];
               end else begin
                  r.value = 0;
                  r.status = 1;
               end
               r.bin = idx[BIN_NUM_W-1:0];
               r.done = 0;
               expected_q.push_back(r);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic signed [VALUE_W-1:0] value, logic [BIN_NUM_W-1:0] bin,
                          logic done, logic status);
         baseline_rsp_type e;
         if (expected_q.size() == 0) begin
            report("response with nothing outstanding");
         end else begin
            e = expected_q.pop_front();
            if (value !== e.value)
               report($sformatf("baseline_value %0d, want %0d", value, e.value));
            if (bin !== e.bin)
               report($sformatf("bin_number %0d, want %0d", bin, e.bin));
            if (done !== e.done)
               report($sformatf("done_res %b, want %b", done, e.done));
            if (status !== e.status)
               report($sformatf("status %b, want %b", status, e.status));
         end
      endtask
   endclass

   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;
   localparam int POOL = 64;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_write_data;

   bsbc_req_if req ();
   bsbc_rsp_if rsp ();

   baseline_scoreboard sb = new();

   bit bounds_ok [DEF_MAX_BINS];
   bit base_ok [DEF_MAX_BINS];
   bit quiet;
   int sent;
   int stall_left = 0;

   binned_spectrum_baseline_clip i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req),
      .rsp_if           (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #200_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_response(rsp.baseline_value, rsp.bin_number, rsp.done_res, rsp.status);
   end

   task send_req(int cmd, int idx, int sample, int first, int last, int hw);
      logic [CMD_W-1:0]          c;
      logic [INDEX_W-1:0]        i;
      logic signed [VALUE_W-1:0] s;
      logic [BOUND_W-1:0]        f;
      logic [BOUND_W-1:0]        l;
      logic [HW_W-1:0]           h;
      c = CMD_W'(cmd);
      i = INDEX_W'(idx);
      s = sample;
      f = BOUND_W'(first);
      l = BOUND_W'(last);
      h = HW_W'(hw);
      req.valid      <= 1'b1;
      req.command    <= c;
      req.index      <= i;
      req.sample     <= s;
      req.bin_first  <= f;
      req.bin_last   <= l;
      req.half_width <= h;
      do
         @(posedge clock);
      while (!req.ready);
      sb.note_request(c, i, s, f, l, h);
      if (c == CMD_COMPUTE) begin
         for (int b = 0; b < sb.active_bins(); b++)
            base_ok[b] = 1;
      end
      sent++;
      if (sent > 500)
         quiet = 1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task wait_idle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_csr(csr_type idx, int unsigned val);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_W'(val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_csr(idx, val);
   endtask

   task load_sample(int idx, logic signed [VALUE_W-1:0] v);
      send_req(CMD_LOAD_SAMPLE, idx, v, $urandom, $urandom, $urandom);
   endtask

   task load_bounds(int idx);
      int f;
      int l;
      if ($urandom_range(0, 5) == 0) begin
         f = $urandom_range(1, 4095);
         l = $urandom_range(0, f - 1);
      end else if ($urandom_range(0, 15) == 0) begin
         f = 4095;
         l = 4095;
      end else begin
         f = $urandom_range(0, POOL - 1);
         l = $urandom_range(f, (f + 7 < POOL) ? f + 7 : POOL - 1);
      end
      send_req(CMD_LOAD_BOUNDS, idx, $urandom, f, l, $urandom);
      if (idx < DEF_MAX_BINS)
         bounds_ok[idx] = 1;
   endtask

   task read_bin(int idx);
      send_req(CMD_READ, idx, $urandom, $urandom, $urandom, $urandom);
   endtask

   task compute();
      for (int b = 0; b < sb.active_bins(); b++)
         if (!bounds_ok[b])
            load_bounds(b);
      send_req(CMD_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task random_read();
      int n;
      int idx;
      n = sb.active_bins();
      idx = $urandom_range(0, n - 1);
      if ($urandom_range(0, 3) != 0 && base_ok[idx])
         read_bin(idx);
      else
         read_bin($urandom_range(n, 4095));
   endtask

   initial begin
      int n;
      quiet = 0;
      sent = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_NUM_BINS;
      csr_write_data = '0;
      req.valid = 1'b0;
      req.command = CMD_LOAD_SAMPLE;
      req.index = '0;
      req.sample = '0;
      req.bin_first = '0;
      req.bin_last = '0;
      req.half_width = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sample pool, with the value extremes at its start
      load_sample(0, 32'sh7fffffff);
      load_sample(1, 32'sh7fffffff);
      load_sample(2, 32'sh80000000);
      load_sample(3, 32'sh80000000);
      for (int s = 4; s < POOL; s++)
         load_sample(s, $urandom);
      load_sample(4095, $urandom);
      for (int i = 0; i < DEF_MAX_ITERATIONS; i++)
         send_req(CMD_LOAD_WIDTH, i, $urandom, $urandom, $urandom,
                  (i == 0) ? 0 : (i == 1) ? 1023 : $urandom_range(0, 1023));

      // single bin, empty iterations
      write_csr(CSR_NUM_BINS, 1);
      write_csr(CSR_NUM_ITERATIONS, 0);
      send_req(CMD_LOAD_BOUNDS, 0, 0, 0, 1, 0);
      bounds_ok[0] = 1;
      compute();
      read_bin(0);
      read_bin(1);
      read_bin(4095);
      send_req(CMD_UNUSED_FIRST, 0, $urandom, $urandom, $urandom, $urandom);
      send_req(CMD_UNUSED_LAST, 4095, $urandom, $urandom, $urandom, $urandom);
      send_req(6, 7, $urandom, $urandom, $urandom, $urandom);
      send_req(CMD_LOAD_BOUNDS, 4095, 0, 4095, 0, 1023);
      send_req(CMD_LOAD_WIDTH, 4095, 0, 0, 0, 1023);

      // two bins, one with reversed bounds
      write_csr(CSR_NUM_BINS, 2);
      send_req(CMD_LOAD_BOUNDS, 1, 0, 4095, 0, 0);
      bounds_ok[1] = 1;
      compute();
      read_bin(0);
      read_bin(1);

      // three bins, widest iteration count with every bit set
      write_csr(CSR_NUM_BINS, 3);
      write_csr(CSR_NUM_ITERATIONS, 127);
      send_req(CMD_LOAD_BOUNDS, 1, 0, 2, 3, 0);
      send_req(CMD_LOAD_BOUNDS, 2, 0, 4095, 4095, 0);
      bounds_ok[2] = 1;
      compute();
      read_bin(1);
      read_bin(2);
      write_csr(CSR_NUM_ITERATIONS, 64);
      compute();
      read_bin(1);

      // num_bins beyond the limit clamps the bins in use
      write_csr(CSR_NUM_BINS, 2047);
      read_bin(0);
      read_bin(2);
      read_bin(1024);
      read_bin(2047);
      write_csr(CSR_NUM_BINS, 1024);
      read_bin(1024);

      while (sent < 520) begin
         if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, 3);
         else
            n = $urandom_range(4, 12);
         write_csr(CSR_NUM_BINS, n);
         write_csr(CSR_NUM_ITERATIONS, $urandom_range(0, 6));
         repeat ($urandom_range(15, 40)) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3:
                  load_sample($urandom_range(0, POOL - 1), $urandom);
               4:
                  load_sample($urandom_range(0, 4095), $urandom);
               5, 6, 7:
                  load_bounds($urandom_range(0, n - 1));
               8:
                  load_bounds($urandom_range(DEF_MAX_BINS, 4095));
               9:
                  send_req(CMD_LOAD_WIDTH, $urandom_range(0, 4095), $urandom, $urandom,
                           $urandom, $urandom);
               10:
                  send_req(CMD_LOAD_WIDTH, $urandom_range(0, 7), $urandom, $urandom,
                           $urandom, $urandom);
               11:
                  send_req($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST), $urandom,
                           $urandom, $urandom, $urandom, $urandom);
               12, 13:
                  compute();
               default:
                  random_read();
            endcase
         end
         compute();
         repeat ($urandom_range(2, 6))
            random_read();
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/bsbc_pkg.sv
sv/bsbc_if.sv
sv/binned_spectrum_baseline_clip.sv
tb/testbench.sv
